// ===== sv/ps2_scancode_key_decoder_top_defines.svh =====
// Assertion macros for the checker file of the PS/2 key decoder.
// No dependencies; include by bare file name.
`ifndef PS2_SCANCODE_KEY_DECODER_TOP_DEFINES_SVH
`define PS2_SCANCODE_KEY_DECODER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define PS2KD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ps2kd checker: property failed");

// Clocked assertion that is also checked during reset.
`define PS2KD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ps2kd checker: property failed");

`endif

// ===== sv/ps2kd_pkg.sv =====
// Package for the PS/2 scan code set 2 key decoder: widths, prefix codes,
// key codes and the two scan-code lookup tables. No dependencies.
package ps2kd_pkg;

   localparam int SCAN_W     = 8;
   localparam int KEY_CODE_W = 5;

   localparam logic [SCAN_W-1:0] PREFIX_EXT = 8'hE0;
   localparam logic [SCAN_W-1:0] PREFIX_REL = 8'hF0;

   localparam logic [KEY_CODE_W-1:0] NO_KEY      = 5'd0;
   localparam logic [KEY_CODE_W-1:0] ARROW_UP    = 5'd1;
   localparam logic [KEY_CODE_W-1:0] ARROW_DOWN  = 5'd2;
   localparam logic [KEY_CODE_W-1:0] ARROW_LEFT  = 5'd3;
   localparam logic [KEY_CODE_W-1:0] ARROW_RIGHT = 5'd4;
   localparam logic [KEY_CODE_W-1:0] KEY_A       = 5'd5;
   localparam logic [KEY_CODE_W-1:0] KEY_Z       = 5'd30;

   // Arrow keys; these follow an E0 prefix.
   function automatic logic [KEY_CODE_W-1:0] lookup_extended(input logic [SCAN_W-1:0] b);
      logic [KEY_CODE_W-1:0] k;
      unique case (b)
         8'h75:   k = ARROW_UP;
         8'h72:   k = ARROW_DOWN;
         8'h6B:   k = ARROW_LEFT;
         8'h74:   k = ARROW_RIGHT;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

   // Letters A..Z map to KEY_A..KEY_Z in alphabet order.
   function automatic logic [KEY_CODE_W-1:0] lookup_normal(input logic [SCAN_W-1:0] b);
      logic [KEY_CODE_W-1:0] k;
      unique case (b)
         8'h1C:   k = 5'd5;
         8'h32:   k = 5'd6;
         8'h21:   k = 5'd7;
         8'h23:   k = 5'd8;
         8'h24:   k = 5'd9;
         8'h2B:   k = 5'd10;
         8'h34:   k = 5'd11;
         8'h33:   k = 5'd12;
         8'h43:   k = 5'd13;
         8'h3B:   k = 5'd14;
         8'h42:   k = 5'd15;
         8'h4B:   k = 5'd16;
         8'h3A:   k = 5'd17;
         8'h31:   k = 5'd18;
         8'h44:   k = 5'd19;
         8'h4D:   k = 5'd20;
         8'h15:   k = 5'd21;
         8'h2D:   k = 5'd22;
         8'h1B:   k = 5'd23;
         8'h2C:   k = 5'd24;
         8'h3C:   k = 5'd25;
         8'h2A:   k = 5'd26;
         8'h1D:   k = 5'd27;
         8'h22:   k = 5'd28;
         8'h35:   k = 5'd29;
         8'h1A:   k = 5'd30;
         default: k = NO_KEY;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/ps2_scancode_key_decoder_top.sv =====
// PS/2 scan code set 2 key decoder, top level: input byte register, prefix
// flags, table lookup and result register. Depends on ps2kd_pkg.
//
//   channel | handshake            | payload                   | beat
//   --------+----------------------+---------------------------+--------------------------
//   req     | req_valid req_ready  | req_scan_byte             | one scan-code byte
//   rsp     | rsp_valid rsp_ready  | rsp_key_code rsp_pressed  | one key event (make/break)
//
// One byte per cycle unless a stalled result holds a keyed byte: a byte waits in
// the input register, where the lookup runs against the prefix flags, and its
// key event is written to the result register when the byte leaves it.
// Reset clears the prefix flags and both valid bits.
// A stalled result holds the input register only when that byte gives a key;
// prefix and unmapped bytes keep flowing.
module ps2_scancode_key_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ps2kd_pkg::SCAN_W-1:0]        req_scan_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ps2kd_pkg::KEY_CODE_W-1:0]    rsp_key_code,
   output logic                                rsp_pressed
);
   import ps2kd_pkg::*;

   logic                  byte_valid_ff, byte_valid_in;
   logic [SCAN_W-1:0]     byte_ff, byte_in;
   logic                  ext_ff, ext_in;
   logic                  rel_ff, rel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_CODE_W-1:0] key_ff, key_in;
   logic                  pressed_ff, pressed_in;

   logic                  is_ext, is_rel, has_key, out_free, advance;
   logic [KEY_CODE_W-1:0] key;

   always_comb begin
      is_ext   = (byte_ff == PREFIX_EXT);
      is_rel   = (byte_ff == PREFIX_REL);
      key      = ext_ff ? lookup_extended(byte_ff) : lookup_normal(byte_ff);
      has_key  = !is_ext && !is_rel && (key != NO_KEY);
      out_free = !rsp_valid_ff || rsp_ready;
      advance  = byte_valid_ff && (!has_key || out_free);
   end

   assign req_ready = !byte_valid_ff || advance;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      ext_in        = ext_ff;
      rel_in        = rel_ff;
      rsp_valid_in  = rsp_valid_ff;
      key_in        = key_ff;
      pressed_in    = pressed_ff;

      if (advance) begin
         byte_valid_in = 1'b0;
         // Prefixes set their flag and leave the other; anything else clears both.
         ext_in = is_ext || (is_rel && ext_ff);
         rel_in = is_rel || (is_ext && rel_ff);
      end
      if (req_valid && req_ready) begin
         byte_valid_in = 1'b1;
         byte_in       = req_scan_byte;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && has_key) begin
         rsp_valid_in = 1'b1;
         key_in       = key;
         pressed_in   = !rel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         ext_ff        <= 1'b0;
         rel_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         ext_ff        <= ext_in;
         rel_ff        <= rel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      byte_ff    <= byte_in;
      key_ff     <= key_in;
      pressed_ff <= pressed_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = key_ff;
   assign rsp_pressed  = pressed_ff;

endmodule

// ===== sv/ps2kd_checker.sv =====
// Port-level checker for the PS/2 key decoder, bound to the top level.
// Depends on ps2kd_pkg and ps2_scancode_key_decoder_top_defines.svh.
`include "ps2_scancode_key_decoder_top_defines.svh"

module ps2kd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ps2kd_pkg::KEY_CODE_W-1:0] rsp_key_code,
   input logic                             rsp_pressed
);
   import ps2kd_pkg::*;

   logic                req_beat;
   logic                rsp_stall;
   logic                key_ok;
   logic [KEY_CODE_W:0] rsp_beat_data;

   assign req_beat      = req_valid && req_ready;
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign key_ok        = (rsp_key_code >= ARROW_UP) && (rsp_key_code <= KEY_Z);
   assign rsp_beat_data = {rsp_key_code, rsp_pressed};

   // A waiting result holds its beat.
   `PS2KD_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_beat_data))

   // Only defined key codes leave the block.
   `PS2KD_ASSERT(a_key_range, clock, reset, rsp_valid |-> key_ok)

   // With the result register empty the input side never stalls.
   `PS2KD_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // Reset drops any pending result.
   `PS2KD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

   // A result needs a byte that was accepted before it.
   `PS2KD_ASSERT(a_no_early_rsp, clock, reset, $past(reset) && !req_beat |=> !rsp_valid)

endmodule

bind ps2_scancode_key_decoder_top ps2kd_checker u_ps2kd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_key_code  (rsp_key_code),
   .rsp_pressed   (rsp_pressed)
);
